FILE: sv/rit_pkg.sv
// Shared types, widths and codes of the ranked insertion table.
// No dependencies; imported by rit_cell and ranked_insertion_table.
package rit_pkg;

  localparam int TABLE_DEPTH_DEF    = 32;
  localparam int CATEGORY_COUNT_DEF = 4;

  localparam int KIND_W  = 2;
  localparam int BIB_W   = 16;
  localparam int CAT_IN_W = 2;
  localparam int TIME_W  = 20;
  localparam int POS_W   = 5;
  localparam int COUNT_W = 16;
  localparam int HELD_W  = 6;

  localparam int IN_DATA_W  = 48;
  localparam int OUT_DATA_W = 64;

  localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

  typedef enum logic [KIND_W-1:0] {
    KIND_INSERT = 2'd0,
    KIND_READ   = 2'd1,
    KIND_CLEAR  = 2'd2,
    KIND_NONE   = 2'd3
  } kind_t;

  typedef struct packed {
    logic              shift;
    logic [BIB_W-1:0]  bib;
    logic [TIME_W-1:0] time_s;
  } rit_ins_t;

endpackage

FILE: sv/rit_cell.sv
// One ranking cell: holds one entry and takes the new record or its left
// neighbor's entry on an insert. Depends on rit_pkg.
module rit_cell #(
  parameter int IDX    = 0,
  parameter int FILL_W = 6
) (
  input  logic                       clk,
  input  rit_pkg::rit_ins_t          ins,
  input  logic [FILL_W-1:0]          fill,
  input  logic                       left_after,
  input  logic [rit_pkg::BIB_W-1:0]  left_bib,
  input  logic [rit_pkg::TIME_W-1:0] left_time,
  output logic                       after,
  output logic [rit_pkg::BIB_W-1:0]  bib,
  output logic [rit_pkg::TIME_W-1:0] time_s
);
  import rit_pkg::*;

  assign after = (fill > FILL_W'(IDX)) && (time_s <= ins.time_s);

  always_ff @(posedge clk) begin
    if (ins.shift && !after) begin
      if (left_after) begin
        bib    <= ins.bib;
        time_s <= ins.time_s;
      end else begin
        bib    <= left_bib;
        time_s <= left_time;
      end
    end
  end

endmodule

FILE: sv/ranked_insertion_table.sv
// Ranked insertion table: one result beat per input beat, valid in the
// cycle after input accept; one item per cycle while the result stream is
// not stalled, set by the single insert step of the cell row and the
// registered result stage. Reset clears fill level, category counts,
// selected category and result valid; table entries hold no reset value
// and are read only below the fill level. Depends on rit_pkg and rit_cell.
module ranked_insertion_table #(
  parameter int TABLE_DEPTH    = rit_pkg::TABLE_DEPTH_DEF,
  parameter int CATEGORY_COUNT = rit_pkg::CATEGORY_COUNT_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [rit_pkg::CAT_IN_W-1:0]     cfg_data,
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  // bib_number[15:0], category[17:16], time_seconds[37:18],
  // rank_position[42:38], zero fill
  input  logic [rit_pkg::IN_DATA_W-1:0]    s_axis_tdata,
  // kind[1:0]
  input  logic [rit_pkg::KIND_W-1:0]       s_axis_tuser,
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  // accepted[0], refused_full[1], entry_valid[2], entry_bib[18:3],
  // entry_time[38:19], category_count[54:39], held_count[60:55], zero fill
  output logic [rit_pkg::OUT_DATA_W-1:0]   m_axis_tdata
);
  import rit_pkg::*;

  localparam int FILL_W = $clog2(TABLE_DEPTH + 1);
  localparam int CAT_W  = $clog2(CATEGORY_COUNT);
  localparam int RD_N   = (TABLE_DEPTH < (1 << POS_W)) ? TABLE_DEPTH : (1 << POS_W);
  localparam int RD_W   = $clog2(RD_N);

  logic [CAT_IN_W-1:0] selected_category;
  logic [FILL_W-1:0]   fill;
  logic [COUNT_W-1:0]  counts [CATEGORY_COUNT];

  logic                in_acc;
  kind_t               kind;
  logic [BIB_W-1:0]    in_bib;
  logic [CAT_IN_W-1:0] in_cat;
  logic [TIME_W-1:0]   in_time;
  logic [POS_W-1:0]    in_pos;

  logic                cat_ok;
  logic [CAT_W-1:0]    cat_idx;
  logic [COUNT_W-1:0]  cnt_cur;
  logic [COUNT_W-1:0]  cnt_inc;
  logic                match;
  logic                full;
  rit_ins_t            ins;

  logic [BIB_W-1:0]    cell_bib   [TABLE_DEPTH];
  logic [TIME_W-1:0]   cell_time  [TABLE_DEPTH];
  logic                cell_after [TABLE_DEPTH];
  logic [BIB_W-1:0]    rd_bib     [RD_N];
  logic [TIME_W-1:0]   rd_time    [RD_N];
  logic [RD_W-1:0]     rd_idx;
  logic                pos_ok;

  logic                o_acc, o_ref, o_val;
  logic [BIB_W-1:0]    o_bib;
  logic [TIME_W-1:0]   o_time;
  logic [COUNT_W-1:0]  o_cnt;
  logic [HELD_W-1:0]   o_held;
  logic                o_acc_next, o_ref_next, o_val_next;
  logic [BIB_W-1:0]    o_bib_next;
  logic [TIME_W-1:0]   o_time_next;
  logic [COUNT_W-1:0]  o_cnt_next;
  logic [FILL_W-1:0]   fill_next;

  assign cfg_ready     = 1'b1;
  assign s_axis_tready = !m_axis_tvalid || m_axis_tready;
  assign in_acc        = s_axis_tvalid && s_axis_tready;

  assign kind    = kind_t'(s_axis_tuser);
  assign in_bib  = s_axis_tdata[15:0];
  assign in_cat  = s_axis_tdata[17:16];
  assign in_time = s_axis_tdata[37:18];
  assign in_pos  = s_axis_tdata[42:38];

  assign cat_ok  = int'(in_cat) < CATEGORY_COUNT;
  assign cat_idx = CAT_W'(in_cat);
  assign cnt_cur = cat_ok ? counts[cat_idx] : '0;
  assign cnt_inc = (cnt_cur == COUNT_MAX) ? cnt_cur : cnt_cur + COUNT_W'(1);
  assign match   = (in_cat == selected_category);
  assign full    = (fill == FILL_W'(TABLE_DEPTH));

  assign ins.shift  = in_acc && (kind == KIND_INSERT) && match && !full;
  assign ins.bib    = in_bib;
  assign ins.time_s = in_time;

  for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
    if (i == 0) begin : g_head
      rit_cell #(.IDX(i), .FILL_W(FILL_W)) u_cell (
        .clk        (clk),
        .ins        (ins),
        .fill       (fill),
        .left_after (1'b1),
        .left_bib   (in_bib),
        .left_time  (in_time),
        .after      (cell_after[i]),
        .bib        (cell_bib[i]),
        .time_s     (cell_time[i])
      );
    end else begin : g_body
      rit_cell #(.IDX(i), .FILL_W(FILL_W)) u_cell (
        .clk        (clk),
        .ins        (ins),
        .fill       (fill),
        .left_after (cell_after[i-1]),
        .left_bib   (cell_bib[i-1]),
        .left_time  (cell_time[i-1]),
        .after      (cell_after[i]),
        .bib        (cell_bib[i]),
        .time_s     (cell_time[i])
      );
    end
  end

  for (genvar r = 0; r < RD_N; r++) begin : g_rd
    assign rd_bib[r]  = cell_bib[r];
    assign rd_time[r] = cell_time[r];
  end

  assign rd_idx = in_pos[RD_W-1:0];
  assign pos_ok = int'(in_pos) < int'(fill);

  always_comb begin
    o_acc_next  = 1'b0;
    o_ref_next  = 1'b0;
    o_val_next  = 1'b0;
    o_bib_next  = '0;
    o_time_next = '0;
    o_cnt_next  = '0;
    fill_next   = fill;
    case (kind)
      KIND_INSERT: begin
        o_cnt_next = cat_ok ? cnt_inc : '0;
        if (match) begin
          if (full) begin
            o_ref_next = 1'b1;
          end else begin
            o_acc_next = 1'b1;
            fill_next  = fill + FILL_W'(1);
          end
        end
      end
      KIND_READ: begin
        o_cnt_next = cnt_cur;
        if (pos_ok) begin
          o_val_next  = 1'b1;
          o_bib_next  = rd_bib[rd_idx];
          o_time_next = rd_time[rd_idx];
        end
      end
      KIND_CLEAR: begin
        fill_next = '0;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      selected_category <= '0;
      fill              <= '0;
      m_axis_tvalid     <= 1'b0;
      for (int c = 0; c < CATEGORY_COUNT; c++) begin
        counts[c] <= '0;
      end
    end else begin
      if (cfg_valid && cfg_ready) begin
        selected_category <= cfg_data;
      end
      if (in_acc) begin
        fill          <= fill_next;
        m_axis_tvalid <= 1'b1;
        if (kind == KIND_CLEAR) begin
          for (int c = 0; c < CATEGORY_COUNT; c++) begin
            counts[c] <= '0;
          end
        end else if (kind == KIND_INSERT && cat_ok) begin
          counts[cat_idx] <= cnt_inc;
        end
      end else if (m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      o_acc  <= o_acc_next;
      o_ref  <= o_ref_next;
      o_val  <= o_val_next;
      o_bib  <= o_bib_next;
      o_time <= o_time_next;
      o_cnt  <= o_cnt_next;
      o_held <= HELD_W'(fill_next);
    end
  end

  assign m_axis_tdata = {3'b000, o_held, o_cnt, o_time, o_bib, o_val, o_ref, o_acc};

  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill <= FILL_W'(TABLE_DEPTH))
    else $error("fill level beyond table depth");

  a_clear_empties: assert property (@(posedge clk) disable iff (rst)
    (in_acc && kind == KIND_CLEAR) |=> (fill == '0))
    else $error("clear left entries in the table");

  a_insert_grows: assert property (@(posedge clk) disable iff (rst)
    ins.shift |=> (fill == $past(fill) + FILL_W'(1)) && o_acc)
    else $error("placed record did not grow the fill level");

  a_acc_ref_excl: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> !(o_acc && o_ref))
    else $error("beat both accepted and refused");

  a_held_matches: assert property (@(posedge clk) disable iff (rst)
    (in_acc && kind != KIND_CLEAR) |=> (o_held == HELD_W'(fill)))
    else $error("held count differs from fill level");

endmodule

FILE: sim/ranked_insertion_table_test.sv
// Self-checking bench for ranked_insertion_table: drives record, read, clear and unused beats
// with random idling on both streams and checks each result against a local ranking model.
// Depends on rit_pkg and the ranked_insertion_table RTL.
`timescale 1ns / 1ps

module ranked_insertion_table_test;
  import rit_pkg::*;

  localparam int DEPTH       = TABLE_DEPTH_DEF;
  localparam int CATS        = CATEGORY_COUNT_DEF;
  localparam int CYCLE_LIMIT = 2_000_000;

  typedef struct packed {
    logic [4:0]          pad;
    logic [POS_W-1:0]    pos;
    logic [TIME_W-1:0]   tsec;
    logic [CAT_IN_W-1:0] cat;
    logic [BIB_W-1:0]    bib;
  } athlete_beat_t;

  typedef struct packed {
    logic [2:0]         pad;
    logic [HELD_W-1:0]  held;
    logic [COUNT_W-1:0] count;
    logic [TIME_W-1:0]  etime;
    logic [BIB_W-1:0]   ebib;
    logic               evalid;
    logic               refused;
    logic               accepted;
  } ranking_result_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CAT_IN_W-1:0]   cfg_data = '0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [IN_DATA_W-1:0]  s_axis_tdata = '0;
  logic [KIND_W-1:0]     s_axis_tuser = KIND_INSERT;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_axis_tdata;

  logic [BIB_W-1:0]    model_bibs [DEPTH];
  logic [TIME_W-1:0]   model_times [DEPTH];
  int                  model_fill = 0;
  logic [COUNT_W-1:0]  model_counts [CATS];
  logic [CAT_IN_W-1:0] model_sel = '0;

  ranking_result_t pending_results [$];
  int              mismatches = 0;
  int              cycles = 0;
  int              stall_left = 0;
  bit              send_idle = 1'b1;
  bit              recv_idle = 1'b1;

  ranked_insertion_table DUT (
    .clk           (clk),
    .rst           (rst),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_data      (cfg_data),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  initial begin
    for (int c = 0; c < CATS; c++) model_counts[c] = '0;
  end

  function automatic int idle_length(input bit enabled);
    int r;
    if (!enabled) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [TIME_W-1:0] pick_time();
    case ($urandom_range(0, 3))
      0, 1:    return TIME_W'($urandom_range(0, 15));
      2:       return TIME_W'($urandom);
      default: return {TIME_W{1'b1}} - TIME_W'($urandom_range(0, 15));
    endcase
  endfunction

  function automatic ranking_result_t rank_table_step(input kind_t k, input athlete_beat_t rec);
    ranking_result_t res;
    int slot;
    res = '0;
    case (k)
      KIND_INSERT: begin
        if (model_counts[rec.cat] != COUNT_MAX) model_counts[rec.cat]++;
        if (rec.cat == model_sel) begin
          if (model_fill < DEPTH) begin
            slot = 0;
            while (slot < model_fill && model_times[slot] <= rec.tsec) slot++;
            for (int i = model_fill; i > slot; i--) begin
              model_bibs[i]  = model_bibs[i-1];
              model_times[i] = model_times[i-1];
            end
            model_bibs[slot]  = rec.bib;
            model_times[slot] = rec.tsec;
            model_fill++;
            res.accepted = 1'b1;
          end else begin
            res.refused = 1'b1;
          end
        end
        res.count = model_counts[rec.cat];
        res.held  = HELD_W'(model_fill);
      end
      KIND_READ: begin
        if (rec.pos < model_fill) begin
          res.evalid = 1'b1;
          res.ebib   = model_bibs[rec.pos];
          res.etime  = model_times[rec.pos];
        end
        res.count = model_counts[rec.cat];
        res.held  = HELD_W'(model_fill);
      end
      KIND_CLEAR: begin
        model_fill = 0;
        for (int c = 0; c < CATS; c++) model_counts[c] = '0;
      end
      default: begin
        res.held = HELD_W'(model_fill);
      end
    endcase
    return res;
  endfunction

  task automatic compare_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
    if (got !== want) begin
      $display("%0t %s mismatch: expected %0h actual %0h", $time, name, want, got);
      mismatches++;
    end
  endtask

  task automatic check_result(input logic [OUT_DATA_W-1:0] word);
    ranking_result_t got;
    ranking_result_t want;
    got = word;
    if (pending_results.size() == 0) begin
      $display("%0t unexpected result beat: expected none actual %h", $time, word);
      mismatches++;
      return;
    end
    want = pending_results.pop_front();
    compare_field("accepted", want.accepted, got.accepted);
    compare_field("refused_full", want.refused, got.refused);
    compare_field("entry_valid", want.evalid, got.evalid);
    compare_field("entry_bib", want.ebib, got.ebib);
    compare_field("entry_time", want.etime, got.etime);
    compare_field("category_count", want.count, got.count);
    compare_field("held_count", want.held, got.held);
    compare_field("zero fill", want.pad, got.pad);
  endtask

  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready) check_result(m_axis_tdata);
    if (stall_left > 0) begin
      stall_left--;
      m_axis_tready <= 1'b0;
    end else begin
      stall_left = idle_length(recv_idle);
      m_axis_tready <= (stall_left == 0);
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  task automatic send_item(input kind_t k, input logic [BIB_W-1:0] bib,
                           input logic [CAT_IN_W-1:0] cat, input logic [TIME_W-1:0] tsec,
                           input logic [POS_W-1:0] pos);
    athlete_beat_t rec;
    int gap;
    rec = '{pad: '0, pos: pos, tsec: tsec, cat: cat, bib: bib};
    s_axis_tdata  <= rec;
    s_axis_tuser  <= k;
    s_axis_tvalid <= 1'b1;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    pending_results.push_back(rank_table_step(k, rec));
    gap = idle_length(send_idle);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic drain_results();
    s_axis_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  task automatic write_selected(input logic [CAT_IN_W-1:0] value);
    drain_results();
    repeat (2) @(posedge clk);
    cfg_data  <= value;
    cfg_valid <= 1'b1;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    model_sel = value;
    cfg_valid <= 1'b0;
  endtask

  task automatic test_directed();
    send_item(KIND_READ, 16'd0, 2'd0, 20'd0, 5'd0);
    send_item(KIND_INSERT, 16'd100, 2'd0, 20'd500, 5'd0);
    send_item(KIND_INSERT, 16'd0, 2'd0, {TIME_W{1'b1}}, 5'd31);
    send_item(KIND_INSERT, 16'hFFFF, 2'd0, 20'd0, 5'd0);
    send_item(KIND_INSERT, 16'd200, 2'd0, 20'd500, 5'd0);
    send_item(KIND_INSERT, 16'd300, 2'd1, 20'd1, 5'd0);
    send_item(KIND_INSERT, 16'd400, 2'd2, 20'd2, 5'd0);
    send_item(KIND_INSERT, 16'd500, 2'd3, 20'd3, 5'd0);
    for (int p = 0; p <= 4; p++) send_item(KIND_READ, 16'hFFFF, CAT_IN_W'(p), '1, POS_W'(p));
    send_item(KIND_READ, 16'd0, 2'd3, 20'd0, 5'd31);
    send_item(KIND_NONE, 16'hFFFF, 2'd3, {TIME_W{1'b1}}, 5'd31);
    send_item(KIND_CLEAR, 16'hFFFF, 2'd3, {TIME_W{1'b1}}, 5'd31);
    send_item(KIND_READ, 16'd0, 2'd0, 20'd0, 5'd0);
    send_item(KIND_READ, 16'd0, 2'd1, 20'd0, 5'd0);
    send_item(KIND_INSERT, 16'd7, 2'd0, 20'd9, 5'd0);
    send_item(KIND_READ, 16'd0, 2'd0, 20'd0, 5'd0);
  endtask

  task automatic test_table_full();
    write_selected(2'd3);
    send_item(KIND_CLEAR, 16'd0, 2'd0, 20'd0, 5'd0);
    for (int i = 0; i < DEPTH + 3; i++) begin
      send_item(KIND_INSERT, BIB_W'($urandom), 2'd3, TIME_W'($urandom_range(0, 7)), 5'd0);
    end
    send_item(KIND_INSERT, 16'd1, 2'd1, 20'd1, 5'd0);
    for (int p = 0; p < DEPTH; p++) send_item(KIND_READ, 16'd0, 2'd3, 20'd0, POS_W'(p));
  endtask

  task automatic test_back_to_back();
    write_selected(2'd2);
    send_item(KIND_CLEAR, 16'd0, 2'd0, 20'd0, 5'd0);
    send_idle = 1'b0;
    recv_idle = 1'b0;
    for (int i = 0; i < 24; i++) begin
      send_item(KIND_INSERT, BIB_W'($urandom), CAT_IN_W'($urandom), pick_time(),
                POS_W'($urandom));
      send_item(KIND_READ, BIB_W'($urandom), CAT_IN_W'($urandom), pick_time(), POS_W'(i));
    end
    send_idle = 1'b1;
    recv_idle = 1'b1;
  endtask

  task automatic send_random_item();
    int r;
    logic [CAT_IN_W-1:0] cat;
    logic [POS_W-1:0] pos;
    r = $urandom_range(0, 99);
    if (r < 58) begin
      cat = ($urandom_range(0, 3) != 0) ? model_sel : CAT_IN_W'($urandom);
      send_item(KIND_INSERT, BIB_W'($urandom), cat, pick_time(), POS_W'($urandom));
    end else if (r < 90) begin
      if (model_fill > 0 && $urandom_range(0, 3) != 0)
        pos = POS_W'($urandom_range(0, model_fill - 1));
      else
        pos = POS_W'($urandom);
      send_item(KIND_READ, BIB_W'($urandom), CAT_IN_W'($urandom), pick_time(), pos);
    end else if (r < 94) begin
      for (int p = 0; p <= model_fill && p < DEPTH; p++) begin
        send_item(KIND_READ, BIB_W'($urandom), model_sel, pick_time(), POS_W'(p));
      end
    end else if (r < 97) begin
      send_item(KIND_CLEAR, BIB_W'($urandom), CAT_IN_W'($urandom), pick_time(),
                POS_W'($urandom));
    end else begin
      send_item(KIND_NONE, BIB_W'($urandom), CAT_IN_W'($urandom), pick_time(),
                POS_W'($urandom));
    end
  endtask

  task automatic test_random_traffic();
    logic [CAT_IN_W-1:0] sel;
    for (int phase = 0; phase < 8; phase++) begin
      case (phase)
        0:       sel = 2'd0;
        1:       sel = 2'd3;
        default: sel = CAT_IN_W'($urandom);
      endcase
      write_selected(sel);
      send_idle = (phase != 2);
      recv_idle = (phase != 3);
      for (int i = 0; i < 50; i++) begin
        if (phase == 4 && i == 25) drain_results();
        send_random_item();
      end
    end
    send_idle = 1'b1;
    recv_idle = 1'b1;
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_table_full();
    test_back_to_back();
    test_random_traffic();
    drain_results();
    repeat (8) @(posedge clk);
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
